@@ hdl/fcts_pkg.sv @@
// ----------------------------------------------------------------------------
// fcts_pkg
// Shared types and constants of the floor-casting texel shader.
// ----------------------------------------------------------------------------
package fcts_pkg;

    localparam int unsigned SCREEN_H_W = 12;
    localparam int unsigned TEX_DIM_W  = 7;
    localparam int unsigned ROW_W      = 11;
    localparam int unsigned POS_W      = 24;
    localparam int unsigned IDX_W      = 12;
    localparam int unsigned COLOR_W    = 32;
    localparam int unsigned SHADE_W    = 23;
    localparam int unsigned PADDR_W    = 4;
    localparam int unsigned PDATA_W    = 32;

    localparam logic [SHADE_W-1:0] COLOR_MASK = 23'h7F7F7F;

    localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd0;
    localparam logic [1:0] REG_TEX_WIDTH     = 2'd1;
    localparam logic [1:0] REG_TEX_HEIGHT    = 2'd2;

    localparam logic [SCREEN_H_W-1:0] SCREEN_HEIGHT_RST = 12'd480;
    localparam logic [TEX_DIM_W-1:0]  TEX_DIM_RST       = 7'd64;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_SHADE = 1'b1;

    // Payload that rides along the pipeline next to the arithmetic.
    typedef struct packed {
        logic               ld;
        logic               ok;
        logic [IDX_W-1:0]   ld_idx;
        logic [COLOR_W-1:0] ld_color;
        logic [POS_W-1:0]   wfx;
        logic [POS_W-1:0]   wfy;
        logic [POS_W-1:0]   px;
        logic [POS_W-1:0]   py;
    } t_carry;

endpackage

@@ hdl/floor_cast_texel_shader.sv @@
// ----------------------------------------------------------------------------
// floor_cast_texel_shader
// Throughput: one word per cycle; the pipeline moves as a whole and holds
// while a finished result waits to be taken.
// Reset: synchronous, active low; clears the valid bits and the registers
// (480, 64, 64). The texture store is not cleared.
// ----------------------------------------------------------------------------
module floor_cast_texel_shader #(
    parameter int unsigned TEX_ENTRIES = 4096,
    parameter int unsigned FRAC_BITS   = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration port.
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [fcts_pkg::PADDR_W-1:0]     paddr,
    input  logic [fcts_pkg::PDATA_W-1:0]     pwdata,
    output logic [fcts_pkg::PDATA_W-1:0]     prdata,
    output logic                             pready,
    // Input channel.
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic                             i_req_type,
    input  logic [fcts_pkg::IDX_W-1:0]       i_texel_index,
    input  logic [fcts_pkg::COLOR_W-1:0]     i_texel_color,
    input  logic [fcts_pkg::ROW_W-1:0]       i_row,
    input  logic [fcts_pkg::POS_W-1:0]       i_wall_floor_x,
    input  logic [fcts_pkg::POS_W-1:0]       i_wall_floor_y,
    input  logic [fcts_pkg::POS_W-1:0]       i_player_x,
    input  logic [fcts_pkg::POS_W-1:0]       i_player_y,
    input  logic [fcts_pkg::POS_W-1:0]       i_wall_dist,
    // Output channel.
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [fcts_pkg::SHADE_W-1:0]     o_shaded_color,
    output logic [fcts_pkg::IDX_W-1:0]       o_tex_index,
    output logic                             o_valid_res
);
    import fcts_pkg::*;

    // The kernel is a straight pipeline:
    //   S0   input register, row test and 2*row - H.
    //   S1   denominator (2*row - H) * 2 * dist and numerator H << 2F.
    //   DIV  a restoring divider with one stage for the saturation test and
    //        one stage per quotient bit, FRAC_BITS + 1 bits in all.
    //   B1   wall * w for both axes.
    //   B2   player * (1.0 - w) for both axes.
    //   B3   blend sum, scaled down by 2^F.
    //   B4   texel coordinate. Since the integer part of the blend times the
    //        texture size is a multiple of the size, the modulo reduces to
    //        the fraction times the size, which is always below the size.
    //   B5   row-major address.
    //   M    texture store access: loads write here and pixels read here, so
    //        loads and reads keep the order of the input words.
    //   O    output register.
    // Every stage advances together when the output register is empty or
    // being drained, so a stall neither drops nor duplicates a word.

    localparam int unsigned AW    = $clog2(TEX_ENTRIES);
    localparam int unsigned QW    = FRAC_BITS + 1;
    localparam int unsigned DENW  = SCREEN_H_W + POS_W + 1;
    localparam int unsigned NUMW  = SCREEN_H_W + 2 * FRAC_BITS;
    localparam int unsigned CW    = DENW + FRAC_BITS + 2;
    localparam int unsigned DS    = FRAC_BITS + 2;
    localparam int unsigned PW    = QW + POS_W;
    localparam int unsigned NSTG  = DS + 9;
    localparam logic [QW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [SCREEN_H_W-1:0] r_screen_h;
    logic [TEX_DIM_W-1:0]  r_tex_w;
    logic [TEX_DIM_W-1:0]  r_tex_h;
    logic                  w_cfg_wr;
    logic [TEX_DIM_W-1:0]  w_tw;
    logic [TEX_DIM_W-1:0]  w_th;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_h <= SCREEN_HEIGHT_RST;
            r_tex_w    <= TEX_DIM_RST;
            r_tex_h    <= TEX_DIM_RST;
        end else if (w_cfg_wr) begin
            case (paddr[3:2])
                REG_SCREEN_HEIGHT: r_screen_h <= pwdata[SCREEN_H_W-1:0];
                REG_TEX_WIDTH:     r_tex_w    <= pwdata[TEX_DIM_W-1:0];
                REG_TEX_HEIGHT:    r_tex_h    <= pwdata[TEX_DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_SCREEN_HEIGHT: prdata = PDATA_W'(r_screen_h);
            REG_TEX_WIDTH:     prdata = PDATA_W'(r_tex_w);
            REG_TEX_HEIGHT:    prdata = PDATA_W'(r_tex_h);
            default:           prdata = '0;
        endcase
    end

    // A zero texture size behaves as a size of one.
    assign w_tw = (r_tex_w == '0) ? TEX_DIM_W'(1) : r_tex_w;
    assign w_th = (r_tex_h == '0) ? TEX_DIM_W'(1) : r_tex_h;

    // ------------------------------------------------------------------
    // Pipeline control.
    // ------------------------------------------------------------------
    logic            w_en;
    logic [NSTG-1:0] r_vld;

    assign w_en    = !o_valid || i_ready;
    assign o_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NSTG-2:0], i_valid};
        end
    end

    assign o_valid = r_vld[NSTG-1];

    // ------------------------------------------------------------------
    // S0: input register.
    // ------------------------------------------------------------------
    t_carry                r_s0_c;
    logic [SCREEN_H_W-1:0] r_s0_diff;
    logic [POS_W-1:0]      r_s0_dist;
    logic [SCREEN_H_W-1:0] w_row2;

    assign w_row2 = {i_row, 1'b0};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0_c.ld       <= (i_req_type == REQ_LOAD);
            r_s0_c.ok       <= (i_req_type == REQ_SHADE) && (w_row2 > r_screen_h)
                               && (i_wall_dist != '0);
            r_s0_c.ld_idx   <= i_texel_index;
            r_s0_c.ld_color <= i_texel_color;
            r_s0_c.wfx      <= i_wall_floor_x;
            r_s0_c.wfy      <= i_wall_floor_y;
            r_s0_c.px       <= i_player_x;
            r_s0_c.py       <= i_player_y;
            r_s0_diff       <= w_row2 - r_screen_h;
            r_s0_dist       <= i_wall_dist;
        end
    end

    // ------------------------------------------------------------------
    // S1 and divider stages. Index 0 holds the operands; stage k+1 is the
    // result of step k.
    // ------------------------------------------------------------------
    t_carry          r_dv_c   [0:DS];
    logic [CW-1:0]   r_dv_rem [0:DS];
    logic [DENW-1:0] r_dv_den [0:DS];
    logic [QW-1:0]   r_dv_q   [0:DS];
    logic            r_dv_sat [0:DS];
    logic [NUMW-1:0] w_num;

    assign w_num = {r_screen_h, {(2 * FRAC_BITS){1'b0}}};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dv_c[0]   <= r_s0_c;
            r_dv_rem[0] <= CW'(w_num);
            r_dv_den[0] <= {(DENW - 1)'(r_s0_diff * r_s0_dist), 1'b0};
            r_dv_q[0]   <= '0;
            r_dv_sat[0] <= 1'b0;
        end
    end

    for (genvar k = 0; k < DS; k++) begin : g_div
        if (k == 0) begin : g_sat
            // A quotient of 2^(F+1) or more saturates anyway.
            logic [CW-1:0] w_lim;
            assign w_lim = CW'(r_dv_den[k]) << QW;
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_dv_c[k+1]   <= r_dv_c[k];
                    r_dv_den[k+1] <= r_dv_den[k];
                    r_dv_rem[k+1] <= r_dv_rem[k];
                    r_dv_q[k+1]   <= r_dv_q[k];
                    r_dv_sat[k+1] <= (r_dv_rem[k] >= w_lim);
                end
            end
        end else begin : g_bit
            localparam int unsigned BIT = DS - 1 - k;
            logic [CW-1:0] w_sub;
            assign w_sub = CW'(r_dv_den[k]) << BIT;
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_dv_c[k+1]   <= r_dv_c[k];
                    r_dv_den[k+1] <= r_dv_den[k];
                    r_dv_sat[k+1] <= r_dv_sat[k];
                    if (r_dv_rem[k] >= w_sub) begin
                        r_dv_rem[k+1] <= r_dv_rem[k] - w_sub;
                        r_dv_q[k+1]   <= r_dv_q[k] | (QW'(1) << BIT);
                    end else begin
                        r_dv_rem[k+1] <= r_dv_rem[k];
                        r_dv_q[k+1]   <= r_dv_q[k];
                    end
                end
            end
        end
    end

    logic [QW-1:0] w_weight;

    assign w_weight = (r_dv_sat[DS] || (r_dv_q[DS] > ONE)) ? ONE : r_dv_q[DS];

    // ------------------------------------------------------------------
    // Blend and texel address stages.
    // ------------------------------------------------------------------
    t_carry               r_b1_c;
    logic [QW-1:0]        r_b1_om;
    logic [PW-1:0]        r_b1_pwx;
    logic [PW-1:0]        r_b1_pwy;
    t_carry               r_b2_c;
    logic [PW-1:0]        r_b2_pwx;
    logic [PW-1:0]        r_b2_pwy;
    logic [PW-1:0]        r_b2_ppx;
    logic [PW-1:0]        r_b2_ppy;
    t_carry               r_b3_c;
    logic [POS_W-1:0]     r_b3_bx;
    logic [POS_W-1:0]     r_b3_by;
    t_carry               r_b4_c;
    logic [TEX_DIM_W-1:0] r_b4_tx;
    logic [TEX_DIM_W-1:0] r_b4_ty;
    t_carry               r_b5_c;
    logic [AW-1:0]        r_b5_addr;

    logic [PW:0]                    w_sum_x;
    logic [PW:0]                    w_sum_y;
    logic [FRAC_BITS+TEX_DIM_W-1:0] w_cx;
    logic [FRAC_BITS+TEX_DIM_W-1:0] w_cy;
    logic [31:0]                    w_addr32;

    assign w_sum_x  = (PW + 1)'(r_b2_pwx) + (PW + 1)'(r_b2_ppx);
    assign w_sum_y  = (PW + 1)'(r_b2_pwy) + (PW + 1)'(r_b2_ppy);
    assign w_cx     = r_b3_bx[FRAC_BITS-1:0] * w_tw;
    assign w_cy     = r_b3_by[FRAC_BITS-1:0] * w_th;
    assign w_addr32 = 32'(w_tw * r_b4_ty) + 32'(r_b4_tx);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b1_c   <= r_dv_c[DS];
            r_b1_om  <= ONE - w_weight;
            r_b1_pwx <= w_weight * r_dv_c[DS].wfx;
            r_b1_pwy <= w_weight * r_dv_c[DS].wfy;

            r_b2_c   <= r_b1_c;
            r_b2_pwx <= r_b1_pwx;
            r_b2_pwy <= r_b1_pwy;
            r_b2_ppx <= r_b1_om * r_b1_c.px;
            r_b2_ppy <= r_b1_om * r_b1_c.py;

            r_b3_c   <= r_b2_c;
            r_b3_bx  <= w_sum_x[FRAC_BITS +: POS_W];
            r_b3_by  <= w_sum_y[FRAC_BITS +: POS_W];

            r_b4_c   <= r_b3_c;
            r_b4_tx  <= w_cx[FRAC_BITS +: TEX_DIM_W];
            r_b4_ty  <= w_cy[FRAC_BITS +: TEX_DIM_W];

            r_b5_c    <= r_b4_c;
            r_b5_addr <= w_addr32[AW-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Texture store.
    // ------------------------------------------------------------------
    logic [COLOR_W-1:0] r_tex_mem [0:TEX_ENTRIES-1];
    logic [COLOR_W-1:0] r_m_texel;
    logic               r_m_ok;
    logic [AW-1:0]      r_m_addr;
    logic [31:0]        w_ld_idx32;

    assign w_ld_idx32 = 32'(r_b5_c.ld_idx);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r_vld[NSTG-3] && r_b5_c.ld) begin
                r_tex_mem[w_ld_idx32[AW-1:0]] <= r_b5_c.ld_color;
            end
            r_m_texel <= r_tex_mem[r_b5_addr];
            r_m_ok    <= r_b5_c.ok;
            r_m_addr  <= r_b5_addr;
        end
    end

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    logic [31:0] w_m_addr32;

    assign w_m_addr32 = 32'(r_m_addr);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_valid_res    <= r_m_ok;
            o_shaded_color <= r_m_ok ? (r_m_texel[SHADE_W:1] & COLOR_MASK) : '0;
            o_tex_index    <= r_m_ok ? w_m_addr32[IDX_W-1:0] : '0;
        end
    end

endmodule

@@ tb/floor_cast_texel_shader_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// floor_cast_texel_shader_tb
// Drives texel loads and floor pixels through the shader in several register
// settings. A local model of the texture store and the blend arithmetic
// predicts every result word, which is checked field by field in order.
// ----------------------------------------------------------------------------
module floor_cast_texel_shader_tb;
    import fcts_pkg::*;

    localparam int unsigned STORE_DEPTH = 4096;
    localparam int unsigned FRAC        = 16;
    localparam int unsigned DRAIN       = 40;
    localparam int unsigned CYCLE_LIMIT = 400000;

    // One input word as it appears on the input ports.
    typedef struct {
        logic               req;
        logic [IDX_W-1:0]   idx;
        logic [COLOR_W-1:0] color;
        logic [ROW_W-1:0]   row;
        logic [POS_W-1:0]   wfx;
        logic [POS_W-1:0]   wfy;
        logic [POS_W-1:0]   px;
        logic [POS_W-1:0]   py;
        logic [POS_W-1:0]   wdist;
    } t_pixel_req;

    // One result word as the shader should return it.
    typedef struct {
        logic [SHADE_W-1:0] shade;
        logic [IDX_W-1:0]   idx;
        logic               ok;
    } t_shade_out;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [PADDR_W-1:0]   paddr = '0;
    logic [PDATA_W-1:0]   pwdata = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic                 i_req_type = 1'b0;
    logic [IDX_W-1:0]     i_texel_index = '0;
    logic [COLOR_W-1:0]   i_texel_color = '0;
    logic [ROW_W-1:0]     i_row = '0;
    logic [POS_W-1:0]     i_wall_floor_x = '0;
    logic [POS_W-1:0]     i_wall_floor_y = '0;
    logic [POS_W-1:0]     i_player_x = '0;
    logic [POS_W-1:0]     i_player_y = '0;
    logic [POS_W-1:0]     i_wall_dist = '0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic [SHADE_W-1:0]   o_shaded_color;
    logic [IDX_W-1:0]     o_tex_index;
    logic                 o_valid_res;

    floor_cast_texel_shader dut (.*);

    // Local copy of the registers and the texture store. The written flags
    // keep the stimulus from ever reading a texel that was never loaded.
    logic [SCREEN_H_W-1:0] cfg_height = SCREEN_HEIGHT_RST;
    logic [TEX_DIM_W-1:0]  cfg_tex_w  = TEX_DIM_RST;
    logic [TEX_DIM_W-1:0]  cfg_tex_h  = TEX_DIM_RST;
    logic [COLOR_W-1:0]    texel_mem [STORE_DEPTH];
    bit                    texel_loaded [STORE_DEPTH];

    t_pixel_req pending_words[$];
    t_shade_out expected_shades[$];
    int         error_count = 0;
    int         cycle_count = 0;
    logic       in_taken = 1'b0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Works out the texel address a pixel reads; returns 0 when the pixel
    // is at or above mid-screen or the distance is zero and nothing is read.
    function automatic bit texel_address(t_pixel_req p, output logic [IDX_W-1:0] addr);
        longint unsigned one, h, num, den, w, tw, th, bx, by, tx, ty;
        one = 64'd1 << FRAC;
        h = cfg_height;
        addr = '0;
        if (2 * longint'(p.row) <= h || p.wdist == 0) return 1'b0;
        num = h << (2 * FRAC);
        den = (2 * longint'(p.row) - h) * 2 * longint'(p.wdist);
        w = num / den;
        // A weight above one is clamped so the blend stays on the segment.
        if (w > one) w = one;
        tw = (cfg_tex_w == 0) ? 1 : cfg_tex_w;
        th = (cfg_tex_h == 0) ? 1 : cfg_tex_h;
        bx = (w * p.wfx + (one - w) * p.px) >> FRAC;
        by = (w * p.wfy + (one - w) * p.py) >> FRAC;
        tx = ((bx * tw) >> FRAC) % tw;
        ty = ((by * th) >> FRAC) % th;
        addr = IDX_W'((tw * ty + tx) % STORE_DEPTH);
        return 1'b1;
    endfunction

    // Queues a word and its expected result. A pixel that would read an
    // unloaded texel gets a load of that texel queued ahead of it.
    task automatic queue_word(t_pixel_req p);
        t_shade_out       r;
        t_pixel_req       ld;
        logic [IDX_W-1:0] addr;
        r = '{default: '0};
        if (p.req == REQ_LOAD) begin
            texel_mem[p.idx] = p.color;
            texel_loaded[p.idx] = 1'b1;
        end else if (texel_address(p, addr)) begin
            if (!texel_loaded[addr]) begin
                ld = p;
                ld.req = REQ_LOAD;
                ld.idx = addr;
                ld.color = $urandom;
                queue_word(ld);
            end
            r.shade = SHADE_W'(texel_mem[addr] >> 1) & COLOR_MASK;
            r.idx = addr;
            r.ok = 1'b1;
        end
        pending_words.push_back(p);
        expected_shades.push_back(r);
    endtask

    function automatic t_pixel_req random_word();
        t_pixel_req p;
        p.req = 1'($urandom_range(1));
        p.idx = IDX_W'($urandom);
        p.color = $urandom;
        p.row = ROW_W'($urandom);
        p.wfx = POS_W'($urandom);
        p.wfy = POS_W'($urandom);
        p.px = POS_W'($urandom);
        p.py = POS_W'($urandom);
        p.wdist = POS_W'($urandom);
        return p;
    endfunction

    // Mostly well-formed floor pixels below mid-screen, with loads and
    // unconstrained noise mixed in.
    task automatic random_phase(int count);
        t_pixel_req p;
        int         lo, hi, pick;
        repeat (count) begin
            p = random_word();
            pick = $urandom_range(99);
            if (pick < 15) begin
                p.req = REQ_LOAD;
            end else if (pick >= 25) begin
                p.req = REQ_SHADE;
                lo = cfg_height / 2 + 1;
                hi = (cfg_height > 2047) ? 2047 : cfg_height;
                if (lo <= hi) p.row = ROW_W'($urandom_range(hi, lo));
                if ($urandom_range(1)) p.wdist = POS_W'($urandom_range(24'hFFFF, 1));
            end
            queue_word(p);
        end
    endtask

    task automatic apb_write(logic [1:0] reg_id, logic [PDATA_W-1:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'({reg_id, 2'b00});
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_registers(int h, int tw, int th);
        apb_write(REG_SCREEN_HEIGHT, h);
        apb_write(REG_TEX_WIDTH, tw);
        apb_write(REG_TEX_HEIGHT, th);
        cfg_height = SCREEN_H_W'(h);
        cfg_tex_w = TEX_DIM_W'(tw);
        cfg_tex_h = TEX_DIM_W'(th);
    endtask

    // Waits until every queued word is taken and every result has come back,
    // then lets the pipeline empty before the registers may change.
    task automatic drain();
        while (pending_words.size() != 0 || expected_shades.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic report(string what, longint unsigned got, longint unsigned want);
        $display("mismatch on %s: got %0h, expected %0h at cycle %0d",
                 what, got, want, cycle_count);
        error_count++;
    endtask

    // Driver: offers a new word at the falling edge once the last one was
    // taken, and idles at random outside the quiet window.
    always @(posedge i_clk) in_taken <= i_valid && o_ready;

    always @(negedge i_clk) begin
        bit quiet;
        t_pixel_req p;
        quiet = (cycle_count > 600 && cycle_count < 1400);
        if (i_rst_n) begin
            i_ready <= quiet || ($urandom_range(99) >= 10);
            if (in_taken) void'(pending_words.pop_front());
            if (!i_valid || in_taken) begin
                if ((pending_words.size() != 0) &&
                    (quiet || $urandom_range(99) >= 10)) begin
                    p = pending_words[0];
                    i_valid <= 1'b1;
                    i_req_type <= p.req;
                    i_texel_index <= p.idx;
                    i_texel_color <= p.color;
                    i_row <= p.row;
                    i_wall_floor_x <= p.wfx;
                    i_wall_floor_y <= p.wfy;
                    i_player_x <= p.px;
                    i_player_y <= p.py;
                    i_wall_dist <= p.wdist;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: every taken result word is held against the oldest prediction.
    always @(posedge i_clk) begin
        t_shade_out r;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_shades.size() == 0) begin
                report("unexpected word", o_tex_index, 0);
            end else begin
                r = expected_shades.pop_front();
                if (o_shaded_color !== r.shade) report("shaded_color", o_shaded_color, r.shade);
                if (o_tex_index !== r.idx) report("tex_index", o_tex_index, r.idx);
                if (o_valid_res !== r.ok) report("valid_res", o_valid_res, r.ok);
            end
        end
    end

    initial begin
        t_pixel_req p;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset geometry.
        set_registers(480, 64, 64);
        p = '{REQ_LOAD, 12'hFFF, 32'hFFFFFFFF, 11'h7FF, 24'hFFFFFF, 24'hFFFFFF,
              24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF};
        queue_word(p);
        p = '{REQ_LOAD, 12'h000, 32'h00000000, '0, '0, '0, '0, '0, '0};
        queue_word(p);
        p = '{REQ_LOAD, 12'h001, 32'h80808080, '0, '0, '0, '0, '0, '0};
        queue_word(p);
        // Rows at and above mid-screen read nothing.
        p = '{REQ_SHADE, '0, '0, 11'd240, 24'h100000, 24'h100000, '0, '0, 24'h10000};
        queue_word(p);
        p.row = '0;
        queue_word(p);
        // Zero distance reads nothing.
        p.row = 11'd400;
        p.wdist = '0;
        queue_word(p);
        // Tiny distance drives the weight past one and it saturates.
        p.wdist = 24'd1;
        queue_word(p);
        p.row = 11'd2047;
        p.wfx = 24'hFFFFFF;
        p.wfy = 24'hFFFFFF;
        queue_word(p);
        // Largest distance gives a weight near zero, so the player wins.
        p.wdist = 24'hFFFFFF;
        p.px = 24'hFFFFFF;
        p.py = 24'h0;
        queue_word(p);
        p.row = 11'd241;
        p.wfx = '0;
        p.wfy = 24'h3F8000;
        p.px = 24'h123456;
        p.py = 24'hFEDCBA;
        p.wdist = 24'h018000;
        queue_word(p);
        random_phase(200);
        drain();

        // Smallest screen and a single-texel texture.
        set_registers(2, 1, 1);
        random_phase(200);
        drain();
        // Tallest legal screen.
        set_registers(2048, 64, 64);
        random_phase(200);
        drain();
        // Widest encodable sizes; addresses wrap past the store.
        set_registers(4095, 127, 127);
        random_phase(200);
        drain();
        // Zero sizes count as one; a zero screen height makes the weight zero.
        set_registers(0, 0, 0);
        random_phase(150);
        drain();
        set_registers(1000, 37, 5);
        random_phase(200);
        drain();
        repeat (3) begin
            set_registers($urandom_range(2048, 2), $urandom_range(64, 1),
                          $urandom_range(64, 1));
            random_phase(120);
            drain();
        end

        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

@@ files.f @@
hdl/fcts_pkg.sv
hdl/floor_cast_texel_shader.sv
tb/floor_cast_texel_shader_tb.sv
